// ----- rtl/core/eesp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the even-edge shortest path engine.
// Holds request codes and the field widths fixed by the item format; no dependencies.
package eesp_pkg;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_SOLVE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam int unsigned END_BITS  = 8;
    localparam int unsigned WIN_BITS  = 16;
    localparam int unsigned DIST_BITS = 32;
    localparam int unsigned CFG_BITS  = 9;

    localparam logic [DIST_BITS-1:0] DIST_INF = '1;

endpackage

// ----- rtl/core/eesp_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the even-edge shortest path engine: request, result, config.
// Depends on eesp_pkg for field widths.
interface eesp_req_if;
    logic                                 valid;
    logic                                 ready;
    eesp_pkg::t_req                       req_type;
    logic [eesp_pkg::END_BITS-1:0]        end_a;
    logic [eesp_pkg::END_BITS-1:0]        end_b;
    logic [eesp_pkg::WIN_BITS-1:0]        edge_weight;
    modport source (output valid, req_type, end_a, end_b, edge_weight, input ready);
    modport sink   (input valid, req_type, end_a, end_b, edge_weight, output ready);
endinterface

interface eesp_res_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 path_found;
    logic [eesp_pkg::DIST_BITS-1:0]       path_length;
    logic                                 edges_dropped;
    modport source (output valid, path_found, path_length, edges_dropped, input ready);
    modport sink   (input valid, path_found, path_length, edges_dropped, output ready);
endinterface

interface eesp_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [eesp_pkg::CFG_BITS-1:0]        vertex_count;
    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

// ----- rtl/core/even_edge_shortest_path_top.sv -----
`timescale 1ns / 1ps
// Even-edge shortest path engine: top level with the search sequencer.
// Depends on eesp_pkg, the channel interfaces and eesp_ram.
//
// A solve request runs Dijkstra over (vertex, parity) states held in one state
// RAM, with the edges in an edge RAM. With n vertices a solve first clears the
// state RAM, then for each settled state scans the active states for the minimum
// and reads every stored edge to relax its neighbours, and last reads the target
// state; at most 2n states settle. A vertex count of zero skips the search.
// Results leave through an output register; a solve that finishes while a
// result still waits holds until the slot frees.
module even_edge_shortest_path_top #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    eesp_cfg_if.sink  i_cfg,
    eesp_req_if.sink  i_req,
    eesp_res_if.source o_res
);

    localparam int NST = 2 * MAX_VERTICES;
    localparam int SW  = $clog2(NST);
    localparam int VB  = SW - 1;
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int NSW = $clog2(NST + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EB  = eesp_pkg::END_BITS;
    localparam int EW  = 2 * EB + WEIGHT_BITS;
    localparam int DB  = eesp_pkg::DIST_BITS;
    localparam int SDW = DB + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_SREQ, S_SDAT, S_SDONE, S_EREQ, S_EDAT, S_RLX,
        S_TREQ, S_TDAT, S_OUT
    } t_state;

    t_state r_state;
    logic [eesp_pkg::CFG_BITS-1:0] r_cfg;
    logic [ECW-1:0] r_edge_total;
    logic           r_overflow;
    logic [NW-1:0]  r_n;
    logic [NSW-1:0] r_idx;
    logic           r_any;
    logic [SW-1:0]  r_best;
    logic [DB-1:0]  r_bestd;
    logic [ECW-1:0] r_eidx;
    logic [SW-1:0]  r_tgt;
    logic [DB-1:0]  r_cand;
    logic           r_res_found;
    logic [DB-1:0]  r_res_len;
    logic           r_out_valid;
    logic           r_out_found;
    logic [DB-1:0]  r_out_len;
    logic           r_out_drop;

    // Edge RAM ports.
    logic           e_we;
    logic [EAW-1:0] e_waddr;
    logic [EW-1:0]  e_wdata;
    logic [EAW-1:0] e_raddr;
    logic [EW-1:0]  e_rdata;

    // State RAM ports: {reached, settled, distance}.
    logic           d_we;
    logic [SW-1:0]  d_waddr;
    logic [SDW-1:0] d_wdata;
    logic [SW-1:0]  d_raddr;
    logic [SDW-1:0] d_rdata;

    logic           req_fire;
    logic           out_free;
    logic           out_load;
    logic [NSW-1:0] two_n;
    logic [EB-1:0]  ed_a;
    logic [EB-1:0]  ed_b;
    logic [WEIGHT_BITS-1:0] ed_w;
    logic [VB-1:0]  cur_v;
    logic           cur_par;
    logic           in_range;
    logic           hit_a;
    logic           hit_b;
    logic [SW-1:0]  rel_tgt;
    logic [DB:0]    sum;
    logic [DB-1:0]  cand;
    logic           sd_better;
    logic           rl_take;

    eesp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    eesp_ram #(.WIDTH(SDW), .DEPTH(NST)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;
    assign out_load    = (r_state == S_OUT) && out_free;

    assign o_res.valid         = r_out_valid;
    assign o_res.path_found    = r_out_found;
    assign o_res.path_length   = r_out_len;
    assign o_res.edges_dropped = r_out_drop;

    // Edge decode and relaxation candidate for the edge just read.
    always_comb begin
        two_n    = NSW'({r_n, 1'b0});
        ed_a     = e_rdata[EW-1 -: EB];
        ed_b     = e_rdata[WEIGHT_BITS +: EB];
        ed_w     = e_rdata[WEIGHT_BITS-1:0];
        cur_v    = r_best[SW-1:1];
        cur_par  = r_best[0];
        in_range = (32'(ed_a) < 32'(r_n)) && (32'(ed_b) < 32'(r_n));
        hit_a    = in_range && (32'(ed_a) == 32'(cur_v));
        hit_b    = in_range && (32'(ed_b) == 32'(cur_v));
        rel_tgt  = hit_a ? {VB'(ed_b), ~cur_par} : {VB'(ed_a), ~cur_par};
        sum      = {1'b0, r_bestd} + (DB + 1)'(ed_w);
        cand     = sum[DB] ? eesp_pkg::DIST_INF : sum[DB-1:0];
        sd_better = d_rdata[DB+1] && !d_rdata[DB] && (!r_any || d_rdata[DB-1:0] < r_bestd);
        rl_take  = !d_rdata[DB] && (!d_rdata[DB+1] || r_cand < d_rdata[DB-1:0]);
    end

    // RAM address and write selection by sequencer state.
    always_comb begin
        e_we    = req_fire && (i_req.req_type == eesp_pkg::REQ_ADD)
                  && (i_req.end_a != i_req.end_b) && (32'(r_edge_total) < 32'(MAX_EDGES));
        e_waddr = r_edge_total[EAW-1:0];
        e_wdata = {i_req.end_a, i_req.end_b, WEIGHT_BITS'(i_req.edge_weight)};
        e_raddr = r_eidx[EAW-1:0];

        d_we    = 1'b0;
        d_waddr = r_idx[SW-1:0];
        d_wdata = {2'b00, eesp_pkg::DIST_INF};
        d_raddr = r_idx[SW-1:0];
        unique case (r_state)
            S_CLR: begin
                d_we = 1'b1;
                if (r_idx == '0) begin
                    d_wdata = {2'b10, {DB{1'b0}}};
                end
            end
            S_SDONE: begin
                d_we    = r_any;
                d_waddr = r_best;
                d_wdata = {2'b11, r_bestd};
            end
            S_EDAT: d_raddr = rel_tgt;
            S_RLX: begin
                d_we    = rl_take;
                d_waddr = r_tgt;
                d_wdata = {2'b10, r_cand};
            end
            S_TREQ: d_raddr = {VB'(r_n - NW'(1)), 1'b0};
            default: ;
        endcase
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg        <= '0;
            r_edge_total <= '0;
            r_overflow   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_cfg <= i_cfg.vertex_count;
            end
            // The output slot fills from S_OUT and empties when the item is taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        priority case (i_req.req_type)
                            eesp_pkg::REQ_ADD: begin
                                if (e_we) begin
                                    r_edge_total <= r_edge_total + ECW'(1);
                                end else if (i_req.end_a != i_req.end_b) begin
                                    r_overflow <= 1'b1;
                                end
                            end
                            eesp_pkg::REQ_CLEAR: r_edge_total <= '0;
                            eesp_pkg::REQ_SOLVE: begin
                                r_n <= (32'(r_cfg) > 32'(MAX_VERTICES))
                                       ? NW'(MAX_VERTICES) : NW'(r_cfg);
                                r_idx <= '0;
                                r_res_found <= 1'b0;
                                r_res_len   <= '0;
                                r_state <= (r_cfg == '0) ? S_OUT : S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLR: begin
                    if (r_idx == two_n - NSW'(1)) begin
                        r_idx   <= '0;
                        r_any   <= 1'b0;
                        r_state <= S_SREQ;
                    end else begin
                        r_idx <= r_idx + NSW'(1);
                    end
                end
                S_SREQ: r_state <= S_SDAT;
                S_SDAT: begin
                    if (sd_better) begin
                        r_any   <= 1'b1;
                        r_best  <= r_idx[SW-1:0];
                        r_bestd <= d_rdata[DB-1:0];
                    end
                    if (r_idx == two_n - NSW'(1)) begin
                        r_state <= S_SDONE;
                    end else begin
                        r_idx   <= r_idx + NSW'(1);
                        r_state <= S_SREQ;
                    end
                end
                S_SDONE: begin
                    r_eidx <= '0;
                    r_idx  <= '0;
                    r_any  <= 1'b0;
                    if (!r_any) begin
                        r_state <= S_TREQ;
                    end else if (r_edge_total == '0) begin
                        r_state <= S_SREQ;
                    end else begin
                        r_state <= S_EREQ;
                    end
                end
                S_EREQ: r_state <= S_EDAT;
                S_EDAT: begin
                    r_tgt  <= rel_tgt;
                    r_cand <= cand;
                    if (hit_a || hit_b) begin
                        r_state <= S_RLX;
                    end else if (r_eidx + ECW'(1) == r_edge_total) begin
                        r_state <= S_SREQ;
                    end else begin
                        r_eidx  <= r_eidx + ECW'(1);
                        r_state <= S_EREQ;
                    end
                end
                S_RLX: begin
                    if (r_eidx + ECW'(1) == r_edge_total) begin
                        r_state <= S_SREQ;
                    end else begin
                        r_eidx  <= r_eidx + ECW'(1);
                        r_state <= S_EREQ;
                    end
                end
                S_TREQ: r_state <= S_TDAT;
                S_TDAT: begin
                    r_res_found <= d_rdata[DB+1];
                    r_res_len   <= d_rdata[DB+1] ? d_rdata[DB-1:0] : '0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_found <= r_res_found;
                        r_out_len   <= r_res_len;
                        r_out_drop  <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // The edge count never passes the store capacity.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_edge_total) <= 32'(MAX_EDGES))
        else $error("edge count beyond capacity");

    // A result that is not found reports zero length.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_len == '0))
        else $error("nonzero length on not-found result");

    // A relaxation only ever writes a state inside the active vertex range.
    a_rlx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RLX && d_we) |-> (32'(r_tgt) < 32'(two_n)))
        else $error("relaxation outside active states");

    // A new result is only loaded into a free output slot.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_res.ready) |=> (r_state == S_OUT))
        else $error("result loaded over a waiting one");
`endif

endmodule

// ----- rtl/core/eesp_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module eesp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
